FILE: src/kbmh_pkg.sv
// ----------------------------------------------------------------------------
// kbmh_pkg: shared types and constants of the keyed byte mix hash
// Item structs, the controller-to-datapath command and the hash constants.
// ----------------------------------------------------------------------------
package kbmh_pkg;

  // Bytes in the mixing hash state, and the key bytes hashed per message.
  localparam int unsigned StateBytes = 32;
  localparam int unsigned KeyBytes   = 16;
  localparam int unsigned IdxW       = $clog2(StateBytes);

  localparam logic [IdxW-1:0] StateLast = IdxW'(StateBytes - 1);
  localparam logic [IdxW-1:0] KeyLast   = IdxW'(KeyBytes - 1);

  // Inner and outer pad bytes of the HMAC form.
  localparam logic [7:0] Ipad = 8'h36;
  localparam logic [7:0] Opad = 8'h5C;

  // Register indexes on the configuration port.
  localparam logic RegKeyLow  = 1'b0;
  localparam logic RegKeyHigh = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word0;
    logic [63:0] digest_word1;
    logic [63:0] digest_word2;
    logic [63:0] digest_word3;
  } out_item_t;

  // Source of the byte that an absorb injects into the working state.
  typedef enum logic [2:0] {
    SrcKey,
    SrcIpad,
    SrcOpad,
    SrcInner,
    SrcData
  } src_sel_e;

  typedef struct packed {
    logic            capture;     // latch the accepted data byte
    logic            clear;       // zero the working state
    logic            absorb;      // run one quarter of the mixing chain
    logic            save_kd;     // working state -> key digest
    logic            save_inner;  // working state -> inner digest
    logic            load_out;    // working state -> output register
    src_sel_e        src;
    logic [IdxW-1:0] idx;         // absorb position and source byte index
    logic [1:0]      phase;       // quarter of the chain, injection in quarter 0
  } dp_cmd_t;

endpackage

FILE: src/kbmh_regs.sv
// ----------------------------------------------------------------------------
// kbmh_regs: key registers behind the configuration port
// Two 64-bit key words, written and read over an APB-style port.
// ----------------------------------------------------------------------------
module kbmh_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output logic [63:0] key_low_o,
  output logic [63:0] key_high_o
);

  logic [63:0] key_low_q, key_low_d;
  logic [63:0] key_high_q, key_high_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // Registers sit eight bytes apart, so address bit 3 picks the register.
  always_comb begin
    key_low_d  = key_low_q;
    key_high_d = key_high_q;
    if (wr_en) begin
      case (paddr[3])
        kbmh_pkg::RegKeyLow:  key_low_d  = pwdata;
        kbmh_pkg::RegKeyHigh: key_high_d = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else begin
      key_low_q  <= key_low_d;
      key_high_q <= key_high_d;
    end
  end

  always_comb begin
    case (paddr[3])
      kbmh_pkg::RegKeyLow:  prdata = key_low_q;
      kbmh_pkg::RegKeyHigh: prdata = key_high_q;
      default:              prdata = '0;
    endcase
  end

  assign key_low_o  = key_low_q;
  assign key_high_o = key_high_q;

endmodule

FILE: src/kbmh_ctrl.sv
// ----------------------------------------------------------------------------
// kbmh_ctrl: sequencer of the keyed byte mix hash
// Walks key hashing, pad absorption, data absorption and the outer hash.
// ----------------------------------------------------------------------------
module kbmh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kbmh_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    StIdle,
    StKey,
    StKeySave,
    StIpad,
    StData,
    StInnerSave,
    StOpad,
    StInner,
    StDone
  } state_e;

  state_e                        state_q, state_d;
  logic [kbmh_pkg::IdxW-1:0]     cnt_q, cnt_d;
  logic [kbmh_pkg::IdxW-1:0]     pos_q, pos_d;
  logic [1:0]                    phase_q, phase_d;
  logic                          in_msg_q, in_msg_d;
  logic                          last_q, last_d;
  logic                          out_valid_q, out_valid_d;
  logic                          quarter_end;
  kbmh_pkg::dp_cmd_t             cmd;

  assign quarter_end = (phase_q == 2'd3);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    phase_d  = phase_q;
    in_msg_d = in_msg_q;
    last_d   = last_q;

    cmd            = '0;
    cmd.src        = kbmh_pkg::SrcData;
    cmd.idx        = cnt_q;
    cmd.phase      = phase_q;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          last_d      = in_last_i;
          phase_d     = 2'd0;
          cnt_d       = '0;
          if (in_msg_q) begin
            state_d = StData;
          end else begin
            cmd.clear = 1'b1;
            state_d   = StKey;
          end
        end
      end
      StKey: begin
        cmd.absorb = 1'b1;
        cmd.src    = kbmh_pkg::SrcKey;
        phase_d    = phase_q + 2'd1;
        if (quarter_end) begin
          cnt_d = cnt_q + kbmh_pkg::IdxW'(1);
          if (cnt_q == kbmh_pkg::KeyLast) begin
            state_d = StKeySave;
          end
        end
      end
      StKeySave: begin
        cmd.save_kd = 1'b1;
        cmd.clear   = 1'b1;
        cnt_d       = '0;
        state_d     = StIpad;
      end
      StIpad: begin
        cmd.absorb = 1'b1;
        cmd.src    = kbmh_pkg::SrcIpad;
        phase_d    = phase_q + 2'd1;
        if (quarter_end) begin
          cnt_d = cnt_q + kbmh_pkg::IdxW'(1);
          if (cnt_q == kbmh_pkg::StateLast) begin
            state_d = StData;
          end
        end
      end
      StData: begin
        cmd.absorb = 1'b1;
        cmd.src    = kbmh_pkg::SrcData;
        cmd.idx    = pos_q;
        phase_d    = phase_q + 2'd1;
        if (quarter_end) begin
          if (last_q) begin
            pos_d    = '0;
            in_msg_d = 1'b0;
            state_d  = StInnerSave;
          end else begin
            pos_d    = pos_q + kbmh_pkg::IdxW'(1);
            in_msg_d = 1'b1;
            state_d  = StIdle;
          end
        end
      end
      StInnerSave: begin
        cmd.save_inner = 1'b1;
        cmd.clear      = 1'b1;
        cnt_d          = '0;
        state_d        = StOpad;
      end
      StOpad: begin
        cmd.absorb = 1'b1;
        cmd.src    = kbmh_pkg::SrcOpad;
        phase_d    = phase_q + 2'd1;
        if (quarter_end) begin
          cnt_d = cnt_q + kbmh_pkg::IdxW'(1);
          if (cnt_q == kbmh_pkg::StateLast) begin
            state_d = StInner;
          end
        end
      end
      StInner: begin
        cmd.absorb = 1'b1;
        cmd.src    = kbmh_pkg::SrcInner;
        phase_d    = phase_q + 2'd1;
        if (quarter_end) begin
          cnt_d = cnt_q + kbmh_pkg::IdxW'(1);
          if (cnt_q == kbmh_pkg::StateLast) begin
            state_d = StDone;
          end
        end
      end
      StDone: begin
        // Wait for the output register to free up before handing over.
        if (!out_valid_q || !out_stall_i) begin
          cmd.load_out = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    out_valid_d = cmd.load_out | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      pos_q       <= '0;
      phase_q     <= 2'd0;
      in_msg_q    <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      phase_q     <= phase_d;
      in_msg_q    <= in_msg_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

FILE: src/kbmh_dp.sv
// ----------------------------------------------------------------------------
// kbmh_dp: datapath of the keyed byte mix hash
// Working state with a quarter-chain mixing unit, digest stores, output item.
// ----------------------------------------------------------------------------
module kbmh_dp (
  input  logic               clk_i,
  input  kbmh_pkg::dp_cmd_t  cmd_i,
  input  logic [7:0]         data_byte_i,
  input  logic [63:0]        key_low_i,
  input  logic [63:0]        key_high_i,
  output kbmh_pkg::out_item_t out_item_o
);

  logic [kbmh_pkg::StateBytes-1:0][7:0] work_q, work_d;
  logic [kbmh_pkg::StateBytes-1:0][7:0] kd_q;
  logic [kbmh_pkg::StateBytes-1:0][7:0] inner_q;
  logic [kbmh_pkg::StateBytes-1:0][7:0] mixed;
  logic [15:0][7:0]                     key_bytes;
  logic [7:0]                           byte_q;
  logic [7:0]                           src_byte;
  kbmh_pkg::out_item_t                  out_q;

  assign key_bytes = {key_high_i, key_low_i};

  always_comb begin
    case (cmd_i.src)
      kbmh_pkg::SrcKey:   src_byte = key_bytes[cmd_i.idx[3:0]];
      kbmh_pkg::SrcIpad:  src_byte = kd_q[cmd_i.idx] ^ kbmh_pkg::Ipad;
      kbmh_pkg::SrcOpad:  src_byte = kd_q[cmd_i.idx] ^ kbmh_pkg::Opad;
      kbmh_pkg::SrcInner: src_byte = inner_q[cmd_i.idx];
      kbmh_pkg::SrcData:  src_byte = byte_q;
      default:            src_byte = '0;
    endcase
  end

  // One quarter of the chain: eight dependent rotate-xor steps on the
  // bottom bytes, then the state turns by eight bytes so the next quarter
  // again works on the bottom. Four quarters return the original order.
  always_comb begin
    logic [kbmh_pkg::StateBytes-1:0][7:0] s;
    s = work_q;
    if (cmd_i.phase == 2'd0) begin
      s[cmd_i.idx] = s[cmd_i.idx] ^ src_byte;
    end
    for (int k = 0; k < 8; k++) begin
      s[k+1] = s[k+1] ^ {s[k][6:0], s[k][7]};
    end
    mixed = {s[7:0], s[kbmh_pkg::StateBytes-1:8]};
  end

  always_comb begin
    work_d = work_q;
    if (cmd_i.clear) begin
      work_d = '0;
    end else if (cmd_i.absorb) begin
      work_d = mixed;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (cmd_i.capture) begin
      byte_q <= data_byte_i;
    end
    if (cmd_i.save_kd) begin
      kd_q <= work_q;
    end
    if (cmd_i.save_inner) begin
      inner_q <= work_q;
    end
    if (cmd_i.load_out) begin
      out_q.digest_word0 <= work_q[7:0];
      out_q.digest_word1 <= work_q[15:8];
      out_q.digest_word2 <= work_q[23:16];
      out_q.digest_word3 <= work_q[31:24];
    end
  end

  assign out_item_o = out_q;

endmodule

FILE: src/keyed_byte_mix_hash_core.sv
// ----------------------------------------------------------------------------
// keyed_byte_mix_hash_core: keyed 32-byte digest of a byte stream, HMAC form
// Mid-message item: accept, then four quarters of the mixing chain.
// First item of a message: key hash, inner pad, then the data byte.
// Last item: outer pad, inner digest, then valid; reset idles with no message.
// ----------------------------------------------------------------------------
module keyed_byte_mix_hash_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input items
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kbmh_pkg::in_item_t  in_item_i,
  // Result items
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kbmh_pkg::out_item_t out_item_o,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);

  // The rate is set by the single shared mixing unit. Each absorbed byte
  // runs a 32-step rotate-xor chain, done as four quarters of eight steps,
  // one quarter per cycle. At the first item of a message the unit first
  // hashes the 16 key bytes (16 absorbs) and then the 32 inner pad bytes;
  // at the last item it hashes the 32 outer pad bytes and the 32 inner
  // digest bytes. After the key hash and after the data, a hand-over state
  // saves the finished state and clears the working state.

  // The result sits in an output register. The next message may start while
  // a digest still waits to be taken; only its own final hand-over waits.

  logic [63:0]       key_low;
  logic [63:0]       key_high;
  kbmh_pkg::dp_cmd_t cmd;

  kbmh_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .key_low_o  (key_low),
    .key_high_o (key_high)
  );

  // The controller sequences the phases and owns the handshakes; the item's
  // last flag goes to it directly since it only steers the sequence.
  kbmh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_item_i.last_byte),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // The datapath holds the working state, the key digest that is kept for
  // the whole message, the inner digest snapshot and the output register.
  kbmh_dp u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .data_byte_i (in_item_i.data_byte),
    .key_low_i   (key_low),
    .key_high_i  (key_high),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: verif/kbmh_digest_checker.sv
// ----------------------------------------------------------------------------
// kbmh_digest_checker: digest predictor and scoreboard for the hash core
// Watches the item channels and the configuration port, keeps its own copy
// of the key and the hash state, and compares every digest item that leaves.
// ----------------------------------------------------------------------------
module kbmh_digest_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  kbmh_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  kbmh_pkg::out_item_t out_item_i,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  input  logic [63:0]         prdata,
  input  logic                pready,
  output int                  fail_count_o,
  output int                  pending_o
);

  // Byte i of a hash state sits at index i.
  typedef logic [kbmh_pkg::StateBytes-1:0][7:0] mix_state_t;

  logic [63:0]               key_low_q;
  logic [63:0]               key_high_q;
  mix_state_t                key_digest_q;
  mix_state_t                inner_q;
  logic [kbmh_pkg::IdxW-1:0] position_q;
  logic                      in_message_q;
  kbmh_pkg::out_item_t       digest_q[$];
  int                        fail_count;

  kbmh_pkg::out_item_t       exp_item;
  logic [3:0][63:0]          exp_words;
  logic [3:0][63:0]          act_words;
  logic [63:0]               reg_value;

  function automatic mix_state_t mix_byte(mix_state_t st, int unsigned pos,
                                          logic [7:0] b);
    mix_state_t  s;
    int unsigned j;
    s = st;
    s[pos % kbmh_pkg::StateBytes] ^= b;
    for (j = 0; j < kbmh_pkg::StateBytes; j++) begin
      s[(j + 1) % kbmh_pkg::StateBytes] ^= {s[j][6:0], s[j][7]};
    end
    return s;
  endfunction

  function automatic mix_state_t hash_key(logic [63:0] lo, logic [63:0] hi);
    mix_state_t   s;
    logic [127:0] key;
    int unsigned  i;
    s   = '0;
    key = {hi, lo};
    for (i = 0; i < kbmh_pkg::KeyBytes; i++) begin
      s = mix_byte(s, i, key[8*i +: 8]);
    end
    return s;
  endfunction

  function automatic mix_state_t hash_padded(mix_state_t kd, logic [7:0] pad);
    mix_state_t  s;
    int unsigned i;
    s = '0;
    for (i = 0; i < kbmh_pkg::StateBytes; i++) begin
      s = mix_byte(s, i, kd[i] ^ pad);
    end
    return s;
  endfunction

  function automatic kbmh_pkg::out_item_t outer_digest(mix_state_t kd,
                                                       mix_state_t inner);
    mix_state_t          s;
    kbmh_pkg::out_item_t d;
    int unsigned         i;
    s = hash_padded(kd, kbmh_pkg::Opad);
    for (i = 0; i < kbmh_pkg::StateBytes; i++) begin
      s = mix_byte(s, i, inner[i]);
    end
    d.digest_word0 = s[7:0];
    d.digest_word1 = s[15:8];
    d.digest_word2 = s[23:16];
    d.digest_word3 = s[31:24];
    return d;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q    = '0;
      key_high_q   = '0;
      key_digest_q = '0;
      inner_q      = '0;
      position_q   = '0;
      in_message_q = 1'b0;
      digest_q.delete();
      fail_count   = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (psel && penable && pready) begin
        reg_value = (paddr[3] == kbmh_pkg::RegKeyLow) ? key_low_q : key_high_q;
        if (pwrite) begin
          if (paddr[3] == kbmh_pkg::RegKeyLow) key_low_q = pwdata;
          else key_high_q = pwdata;
        end else if (prdata !== reg_value) begin
          $display("%0t key register read at %h: expected %h, actual %h",
                   $time, paddr, reg_value, prdata);
          fail_count++;
        end
      end

      if (in_valid_i && !in_stall_i) begin
        // The key is only hashed when a new message opens.
        if (!in_message_q) begin
          key_digest_q = hash_key(key_low_q, key_high_q);
          inner_q      = hash_padded(key_digest_q, kbmh_pkg::Ipad);
          position_q   = '0;
          in_message_q = 1'b1;
        end
        inner_q    = mix_byte(inner_q, position_q, in_item_i.data_byte);
        position_q = position_q + 1'b1;
        if (in_item_i.last_byte) begin
          digest_q.push_back(outer_digest(key_digest_q, inner_q));
          in_message_q = 1'b0;
          position_q   = '0;
        end
      end

      if (out_valid_i && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          $display("%0t unexpected digest item: expected none, actual %h",
                   $time, out_item_i);
          fail_count++;
        end else begin
          exp_item  = digest_q.pop_front();
          exp_words = exp_item;
          act_words = out_item_i;
          // digest_word0 is the most significant word of the packed item.
          for (int k = 0; k < 4; k++) begin
            if (exp_words[3-k] !== act_words[3-k]) begin
              $display("%0t digest_word%0d mismatch: expected %h, actual %h",
                       $time, k, exp_words[3-k], act_words[3-k]);
              fail_count++;
            end
          end
        end
      end

      pending_o    <= digest_q.size();
      fail_count_o <= fail_count;
    end
  end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for keyed_byte_mix_hash_core
// Programs keys over the configuration port, streams messages of random
// length with random idling on both channels, and reports the checker's
// verdict once every digest has come back.
// ----------------------------------------------------------------------------
module tb_top;

  // About 1100 random items, split into messages.
  localparam int unsigned RandomItems   = 1100;
  // New keys are programmed every few messages.
  localparam int unsigned PhaseMessages = 8;
  // This is ample for the core to finish any item that is still in flight,
  // a one-byte message included.
  localparam int unsigned IdleWait      = 600;
  // The slowest correct run is every item a one-byte message plus stalls,
  // roughly 1200 such items; the limit is a few times that run.
  localparam int unsigned CycleLimit    = 3_000_000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  kbmh_pkg::in_item_t  in_item_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  kbmh_pkg::out_item_t out_item_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [3:0]          paddr       = '0;
  logic [63:0]         pwdata      = '0;
  logic [63:0]         prdata;
  logic                pready;

  // While calm is high neither side idles.
  logic        calm        = 1'b0;
  int          fail_count;
  int          pending;
  int unsigned cycles      = 0;
  int unsigned random_items;
  int unsigned msg;
  int unsigned len;

  keyed_byte_mix_hash_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  kbmh_digest_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #4 clk_i = ~clk_i;

  // The result side stalls now and then, except in the calm stretch.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 8);
  end

  // Hard stop in case the core hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // One APB transfer: setup phase, access phase, then an idle phase so that
  // back-to-back transfers never drive psel twice in one step.
  task automatic apb_access(input logic wr, input logic reg_sel,
                            input logic [63:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {reg_sel, 3'b000};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes the low key word, the high one or both, then reads both back so
  // that the checker can compare them.
  task automatic program_key(input logic [63:0] lo, input logic [63:0] hi,
                             input int unsigned which);
    if (which != 1) apb_access(1'b1, kbmh_pkg::RegKeyLow, lo);
    if (which != 0) apb_access(1'b1, kbmh_pkg::RegKeyHigh, hi);
    apb_access(1'b0, kbmh_pkg::RegKeyLow, '0);
    apb_access(1'b0, kbmh_pkg::RegKeyHigh, '0);
  endtask

  // Random key word, with the all-zero and all-one extremes mixed in.
  function automatic logic [63:0] random_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Offers one item and returns at the edge where it is accepted. The valid
  // stays high afterwards so that the next item can follow without a gap.
  task automatic send_byte(input logic [7:0] data, input logic last);
    if (!calm && ($urandom_range(0, 99) < 8)) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    in_item_i.data_byte <= data;
    in_item_i.last_byte <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stops sending, waits until every digest has been seen, then lets the
  // core finish any item that causes no digest. The checker's count is
  // registered, hence the first wait.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (IdleWait) @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. First a one-byte message under the reset key.
    send_byte(8'h00, 1'b1);
    wait_idle();

    // All-ones key, then a one-byte and a three-byte message back to back.
    program_key('1, '1, 2);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b1);
    wait_idle();

    // Key change in the middle of a message: the open message must finish
    // with the old key and only the next message sees the new one.
    program_key(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 2);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    wait_idle();
    program_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 2);
    send_byte(8'h5A, 1'b1);
    send_byte(8'h7F, 1'b1);
    wait_idle();

    // Only one word changes; the other keeps its value.
    program_key('0, '0, 0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b1);

    // Random part: mostly short messages, some one byte long, and some that
    // run past 32 bytes so that the absorb position wraps.
    random_items = 0;
    msg          = 0;
    while (random_items < RandomItems) begin
      if (msg % PhaseMessages == 0) begin
        wait_idle();
        program_key(random_key(), random_key(), $urandom_range(0, 3));
      end
      calm <= (msg >= 30) && (msg < 45);
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(33, 70);
        1, 2:    len = 1;
        default: len = $urandom_range(2, 12);
      endcase
      for (int unsigned i = 0; i < len; i++) begin
        send_byte(8'($urandom_range(0, 255)), i == len - 1);
        random_items++;
      end
      msg++;
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: keyed_byte_mix_hash_core.f
src/kbmh_pkg.sv
src/kbmh_regs.sv
src/kbmh_ctrl.sv
src/kbmh_dp.sv
src/keyed_byte_mix_hash_core.sv
verif/kbmh_digest_checker.sv
verif/tb_top.sv
